// File: rtl/msa_pkg.sv
// Shared constants, types and pipeline control struct of the six-channel moving average.
`default_nettype none

package msa_pkg;

    localparam int CHANNELS = 6;
    localparam int SAMPLE_W = 16;
    localparam int SUM_W    = 20;
    localparam int WINDOW   = 10;
    localparam int PTR_W    = $clog2(WINDOW);
    localparam int PROD_W   = 2 * SUM_W;

    localparam int SUM_MAX = WINDOW * 32767;
    localparam int SUM_MIN = -(WINDOW * 32768);

    // Reciprocal of the window length scaled by two to the sum width.
    localparam logic [SUM_W-1:0] RECIP     = SUM_W'((64'd1 << SUM_W) / WINDOW);
    localparam logic [SUM_W-1:0] WINDOW_V  = SUM_W'(WINDOW);
    localparam logic [PTR_W-1:0] PTR_LAST  = PTR_W'(WINDOW - 1);
    localparam logic [SUM_W:0]   REM_LIMIT = (SUM_W + 1)'(2 * WINDOW);

    typedef logic [CHANNELS-1:0][SAMPLE_W-1:0] row_t;
    typedef logic [CHANNELS-1:0][SUM_W-1:0]    sum_row_t;

    typedef struct packed {
        logic advance;
        logic valid;
    } pipe_ctl_t;

endpackage

`default_nettype wire

// File: rtl/six_channel_moving_average.sv
// Top level of the six-channel ten-sample moving-average filter.
// The block accepts one six-axis sample per clock cycle while the output is not stalled, and
// returns one item of six window averages per sample, in order. Each channel keeps its last
// WINDOW samples in one circular history memory (one row of six samples per entry, with a
// registered read) and a running sum, so the update is one add and subtract per item; the
// average is the sum divided by WINDOW, truncated toward zero, computed by a reciprocal
// multiply and a one-step correction over three pipeline stages. After reset the history
// counts as all zero without any clearing pass, so the block is ready at once. A stalled
// output holds the whole pipeline, and the input then stalls in the same cycle.
`default_nettype none

module six_channel_moving_average import msa_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic signed [15:0] accel_x,
    input  wire logic signed [15:0] accel_y,
    input  wire logic signed [15:0] accel_z,
    input  wire logic signed [15:0] rate_x,
    input  wire logic signed [15:0] rate_y,
    input  wire logic signed [15:0] rate_z,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic signed [15:0]      avg_accel_x,
    output logic signed [15:0]      avg_accel_y,
    output logic signed [15:0]      avg_accel_z,
    output logic signed [15:0]      avg_rate_x,
    output logic signed [15:0]      avg_rate_y,
    output logic signed [15:0]      avg_rate_z
);

    logic      advance;
    logic      accept;
    logic      v1_reg;
    logic      v2_reg;
    logic      v3_reg;
    logic      v4_reg;
    logic      out_valid_reg;
    row_t      in_row;
    row_t      fresh;
    row_t      oldest;
    sum_row_t  sums;
    row_t      avg_row;
    pipe_ctl_t accum_ctl;
    pipe_ctl_t div_ctl;

    assign advance  = !(out_valid_reg && out_stall);
    assign accept   = in_valid && advance;
    assign in_stall = !advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg        <= 1'b0;
            v2_reg        <= 1'b0;
            v3_reg        <= 1'b0;
            v4_reg        <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (advance)
        begin
            v1_reg        <= accept;
            v2_reg        <= v1_reg;
            v3_reg        <= v2_reg;
            v4_reg        <= v3_reg;
            out_valid_reg <= v4_reg;
        end
    end

    assign in_row    = {rate_z, rate_y, rate_x, accel_z, accel_y, accel_x};
    assign accum_ctl = '{advance: advance, valid: v1_reg};
    assign div_ctl   = '{advance: advance, valid: v4_reg};

    msa_history u_history
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .accept  (accept),
        .advance (advance),
        .sample  (in_row),
        .fresh   (fresh),
        .oldest  (oldest)
    );

    msa_accum u_accum
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctl    (accum_ctl),
        .fresh  (fresh),
        .oldest (oldest),
        .sums   (sums)
    );

    msa_divider u_divider
    (
        .clk   (clk),
        .rst_n (rst_n),
        .ctl   (div_ctl),
        .sums  (sums),
        .avg   (avg_row)
    );

    assign out_valid   = out_valid_reg;
    assign avg_accel_x = $signed(avg_row[0]);
    assign avg_accel_y = $signed(avg_row[1]);
    assign avg_accel_z = $signed(avg_row[2]);
    assign avg_rate_x  = $signed(avg_row[3]);
    assign avg_rate_y  = $signed(avg_row[4]);
    assign avg_rate_z  = $signed(avg_row[5]);

    a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_stall |-> !accept)
        else $error("item accepted while the pipeline is held");

    a_item_count: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> v1_reg)
        else $error("accepted item lost from the first stage");

endmodule

`default_nettype wire

// File: rtl/msa_history.sv
// Circular sample history memory with write pointer and first-wrap flag.
`default_nettype none

module msa_history import msa_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic accept,
    input  wire logic advance,
    input  wire row_t sample,
    output row_t      fresh,
    output row_t      oldest
);

    row_t             mem [WINDOW];
    logic [PTR_W-1:0] ptr_reg;
    logic [PTR_W-1:0] ptr_next;
    logic             wrapped_reg;
    logic             wrapped_next;
    logic             wrapped_s1_reg;
    row_t             rdata_reg;
    row_t             fresh_reg;

    always_comb
    begin
        ptr_next     = ptr_reg;
        wrapped_next = wrapped_reg;
        if (accept)
        begin
            if (ptr_reg == PTR_LAST)
            begin
                ptr_next     = '0;
                wrapped_next = 1'b1;
            end
            else
            begin
                ptr_next = ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg        <= '0;
            wrapped_reg    <= 1'b0;
            wrapped_s1_reg <= 1'b0;
        end
        else
        begin
            ptr_reg     <= ptr_next;
            wrapped_reg <= wrapped_next;
            if (advance)
            begin
                wrapped_s1_reg <= wrapped_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            mem[ptr_reg] <= sample;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            rdata_reg <= mem[ptr_reg];
            fresh_reg <= sample;
        end
    end

    // Until the pointer has wrapped once, the leaving sample is a reset zero.
    assign oldest = wrapped_s1_reg ? rdata_reg : '0;
    assign fresh  = fresh_reg;

    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= PTR_LAST)
        else $error("history pointer out of range");

    a_wrap_at_end: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(wrapped_reg) |-> $past(ptr_reg) == PTR_LAST && $past(accept))
        else $error("history wrapped away from the last entry");

endmodule

`default_nettype wire

// File: rtl/msa_accum.sv
// Running window sums, one per channel.
`default_nettype none

module msa_accum import msa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pipe_ctl_t ctl,
    input  wire row_t      fresh,
    input  wire row_t      oldest,
    output sum_row_t       sums
);

    sum_row_t sum_reg;
    sum_row_t sum_next;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            sum_next[c] = sum_reg[c] + SUM_W'($signed(fresh[c]))
                        - SUM_W'($signed(oldest[c]));
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg <= '0;
        end
        else if (ctl.advance && ctl.valid)
        begin
            sum_reg <= sum_next;
        end
    end

    assign sums = sum_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_bound
        a_sum_bound: assert property (@(posedge clk) disable iff (!rst_n)
            $signed(sum_reg[g]) <= SUM_MAX && $signed(sum_reg[g]) >= SUM_MIN)
            else $error("window sum outside the range of a full window");
    end

endmodule

`default_nettype wire

// File: rtl/msa_divider.sv
// Pipelined signed division of the window sums by the window length.
`default_nettype none

module msa_divider import msa_pkg::*;
(
    input  wire logic      clk,
    input  wire logic      rst_n,
    input  wire pipe_ctl_t ctl,
    input  wire sum_row_t  sums,
    output row_t           avg
);

    logic [SUM_W-1:0]  mag_s3_reg [CHANNELS];
    logic              neg_s3_reg [CHANNELS];
    logic [SUM_W-1:0]  mag_s4_reg [CHANNELS];
    logic              neg_s4_reg [CHANNELS];
    logic [SUM_W-1:0]  q0_s4_reg  [CHANNELS];
    row_t              avg_reg;

    logic [PROD_W-1:0] prod    [CHANNELS];
    logic [SUM_W-1:0]  qw      [CHANNELS];
    logic [SUM_W-1:0]  rem     [CHANNELS];
    logic [SUM_W-1:0]  quot    [CHANNELS];
    logic [SUM_W-1:0]  res     [CHANNELS];
    row_t              avg_next;

    always_comb
    begin
        for (int c = 0; c < CHANNELS; c++)
        begin
            prod[c]     = PROD_W'(mag_s3_reg[c]) * PROD_W'(RECIP);
            qw[c]       = q0_s4_reg[c] * WINDOW_V;
            rem[c]      = mag_s4_reg[c] - qw[c];
            quot[c]     = q0_s4_reg[c] + SUM_W'(rem[c] >= WINDOW_V);
            res[c]      = neg_s4_reg[c] ? (~quot[c] + 1'b1) : quot[c];
            avg_next[c] = res[c][SAMPLE_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.advance)
        begin
            for (int c = 0; c < CHANNELS; c++)
            begin
                neg_s3_reg[c] <= sums[c][SUM_W-1];
                mag_s3_reg[c] <= sums[c][SUM_W-1] ? (~sums[c] + 1'b1) : sums[c];
                neg_s4_reg[c] <= neg_s3_reg[c];
                mag_s4_reg[c] <= mag_s3_reg[c];
                q0_s4_reg[c]  <= prod[c][PROD_W-1:SUM_W];
            end
            avg_reg <= avg_next;
        end
    end

    assign avg = avg_reg;

    for (genvar g = 0; g < CHANNELS; g++)
    begin : g_rem
        a_rem_bound: assert property (@(posedge clk) disable iff (!rst_n)
            ctl.valid |-> {1'b0, rem[g]} < REM_LIMIT)
            else $error("reciprocal quotient off by more than one");
    end

endmodule

`default_nettype wire
